// ===== rtl/core/uuidp_pkg.sv =====
// Shared types and constants for the UUID text parser.
`default_nettype none
package uuidp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  // Body is 36 chars: 32 digits plus 4 dashes.
  localparam logic [5:0] BODY_LEN = 6'd36;
  localparam logic [5:0] DASH_K0  = 6'd8;
  localparam logic [5:0] DASH_K1  = 6'd13;
  localparam logic [5:0] DASH_K2  = 6'd18;
  localparam logic [5:0] DASH_K3  = 6'd23;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned ACC_W = 128;

  // Classified byte as it travels from front to back.
  typedef struct packed {
    logic       start;
    logic       is_open;
    logic       is_dash;
    logic       is_close;
    logic       is_hex;
    logic [3:0] digit;
  } cls_t;

  // Hex digit decode; valid flag in bit 4.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/uuidp_front.sv =====
// Front end: classifies each incoming byte.
`default_nettype none
module uuidp_front (
  input  wire logic [7:0]    char_in,
  input  wire logic          start_req,
  output uuidp_pkg::cls_t    cls
);

  logic [4:0] hx;

  always_comb begin
    hx           = uuidp_pkg::hex_decode(char_in);
    cls.start    = start_req;
    cls.is_open  = (char_in == uuidp_pkg::CH_OPEN);
    cls.is_dash  = (char_in == uuidp_pkg::CH_DASH);
    cls.is_close = (char_in == uuidp_pkg::CH_CLOSE);
    cls.is_hex   = hx[4];
    cls.digit    = hx[3:0];
  end

endmodule
`default_nettype wire

// ===== rtl/core/uuidp_queue.sv =====
// Short FIFO of classified items between front and back.
`default_nettype none
module uuidp_queue #(
  parameter int unsigned DEPTH = uuidp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire uuidp_pkg::cls_t  push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      uuidp_pkg::cls_t  pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  uuidp_pkg::cls_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/uuidp_back.sv =====
// Back end: parse state, value accumulator and result register.
`default_nettype none
module uuidp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output      logic             q_ready,
  input  wire uuidp_pkg::cls_t  q_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic             out_status,
  output      logic [31:0]      out_time_low,
  output      logic [15:0]      out_time_mid,
  output      logic [15:0]      out_time_high,
  output      logic [63:0]      out_tail_bytes,
  output      logic [5:0]       out_stop_offset
);

  localparam int unsigned AW = uuidp_pkg::ACC_W;

  logic [5:0]    pos_r,    pos_nxt;
  logic          brace_r,  brace_nxt;
  logic          active_r, active_nxt;
  logic [AW-1:0] acc_r,    acc_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          status_r;
  logic [AW-1:0] value_r;
  logic [5:0]    stop_r;

  logic          fire, res, ok, sep;
  logic [5:0]    pos_e, k, stop;
  logic          brace_e, act_e;
  logic [AW-1:0] acc_e;

  assign q_ready = !out_valid_r || out_ready;
  assign fire    = q_valid && q_ready;

  always_comb begin
    act_e   = q_data.start | active_r;
    pos_e   = q_data.start ? 6'd0 : pos_r;
    brace_e = q_data.start ? 1'b0 : brace_r;
    acc_e   = q_data.start ? '0 : acc_r;
    k       = pos_e - {5'd0, brace_e};
    sep     = (k == uuidp_pkg::DASH_K0) || (k == uuidp_pkg::DASH_K1) ||
              (k == uuidp_pkg::DASH_K2) || (k == uuidp_pkg::DASH_K3);

    pos_nxt    = pos_r;
    brace_nxt  = brace_r;
    active_nxt = active_r;
    acc_nxt    = acc_r;
    res        = 1'b0;
    ok         = 1'b0;
    stop       = pos_e;

    if (fire) begin
      pos_nxt    = pos_e;
      brace_nxt  = brace_e;
      active_nxt = act_e;
      acc_nxt    = acc_e;
      if (act_e) begin
        if (pos_e == 6'd0 && q_data.is_open) begin
          brace_nxt = 1'b1;
          pos_nxt   = 6'd1;
        end else if (k >= uuidp_pkg::BODY_LEN) begin
          res = 1'b1;
          if (brace_e) begin
            ok   = q_data.is_close;
            stop = q_data.is_close ? pos_e + 6'd1 : pos_e;
          end else begin
            ok = !q_data.is_hex;
          end
        end else if (sep) begin
          if (q_data.is_dash) begin
            pos_nxt = pos_e + 6'd1;
          end else begin
            res = 1'b1;
          end
        end else if (q_data.is_hex) begin
          acc_nxt = {acc_e[AW-5:0], q_data.digit};
          pos_nxt = pos_e + 6'd1;
        end else begin
          res = 1'b1;
        end
        if (res) begin
          active_nxt = 1'b0;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (fire && res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      brace_r     <= 1'b0;
      active_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      brace_r     <= brace_nxt;
      active_r    <= active_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res) begin
      status_r <= !ok;
      value_r  <= ok ? acc_e : '0;
      stop_r   <= stop;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_time_low    = value_r[127:96];
  assign out_time_mid    = value_r[95:80];
  assign out_time_high   = value_r[79:64];
  assign out_tail_bytes  = value_r[63:0];
  assign out_stop_offset = stop_r;

endmodule
`default_nettype wire

// ===== rtl/core/uuid_text_parser.sv =====
// Top level of the UUID text parser: front classifier, item queue, parse back end.
`default_nettype none
// Parses the text form of a UUID (optional '{', hex groups 8-4-4-4-12 split
// by dashes, either letter case) one byte per item and gives one result per
// string: at the first malformed byte, or at the byte after the last group
// (a closing brace when the string opened with one, otherwise any byte that
// is not a hex digit; a zero byte does). in_start_req marks the first byte of
// a string and drops any string in progress without a result; bytes that
// arrive while no string is open are swallowed. On error the status is 1,
// the value fields read zero and the stop offset names the offending byte.
// On success the stop offset is 38 for a braced string and 36 otherwise.
// Throughput is one byte per clock sustained while out_ready takes each result.
// A byte is classified as it is accepted and written into a QUEUE_DEPTH-entry
// queue; the back end takes one queue entry per cycle while its output
// register is free or being read, and its result lands in that register, so a
// result waiting on out_ready does not stop input until the queue fills. An
// accepted byte passes the queue, then the output register, to out_valid.
module uuid_text_parser #(
  parameter int unsigned QUEUE_DEPTH = uuidp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_start_req,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_status,
  output      logic [31:0] out_time_low,
  output      logic [15:0] out_time_mid,
  output      logic [15:0] out_time_high,
  output      logic [63:0] out_tail_bytes,
  output      logic [5:0]  out_stop_offset
);

  uuidp_pkg::cls_t in_cls;
  uuidp_pkg::cls_t q_cls;
  logic            q_valid;
  logic            q_ready;

  // byte -> class flags and digit value
  uuidp_front u_front (
    .char_in   (in_char_in),
    .start_req (in_start_req),
    .cls       (in_cls)
  );

  // decouples input handshake from the parser
  uuidp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (in_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cls)
  );

  // position tracking, group checks, 128-bit assembly, result register
  uuidp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_cls),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_time_low    (out_time_low),
    .out_time_mid    (out_time_mid),
    .out_time_high   (out_time_high),
    .out_tail_bytes  (out_tail_bytes),
    .out_stop_offset (out_stop_offset)
  );

endmodule
`default_nettype wire
